[rtl/rmst_pkg.sv]
// Shared types and constants for the range-minimum segment tree.
`default_nettype none
package rmst_pkg;

	// Stored value width and the value of an untouched node
	localparam int VAL_W = 60;
	localparam int IDX_W = 10;
	localparam logic [VAL_W-1:0] INF_VAL = 60'd1000000000000000000;

	// Operation selector carried on the input tuser
	localparam logic FUNC_UPDATE = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_U_READ,
		ST_U_WRITE,
		ST_Q_LEFT,
		ST_Q_RIGHT,
		ST_Q_DONE
	} state_t;

endpackage
`default_nettype wire

[rtl/rmst_ram.sv]
// Generic simple dual-port RAM, one write port and one registered read port.
`default_nettype none
module rmst_ram #(
	parameter int WIDTH = 60,
	parameter int DEPTH = 2048
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire                     re,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/range_min_segment_tree.sv]
// Range-minimum segment tree: sequencer around one node RAM with a registered read.
// Update: an accept step, then per tree level a read step and a min-and-write step,
//   from the leaf up to the root.
// Query: the accept, then for a non-empty range a left and a right step per level on
//   the single RAM read port and a last bound check, then the hand-off to the output
//   register, which waits while a result item is stalled.
//   One item is in work at a time.
// Reset: a clearing pass writes 1e18 into all 2*LEAVES nodes, one a cycle; the input
//   is not ready until the pass ends.
`default_nettype none
module range_min_segment_tree #(
	parameter int LEAVES = 1024
) (
	input  wire         clk,
	input  wire         arst_n,
	// input items
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [95:0]  s_axis_tdata,  // position[9:0], new_value[69:10], range_low[79:70],
	                                   // range_high[89:80], zero[95:90]
	input  wire         s_axis_tuser,  // func[0]
	// result items
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [63:0] m_axis_tdata   // minimum[59:0], zero[63:60]
);

	localparam int DEPTH = 2 * LEAVES;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int VW    = rmst_pkg::VAL_W;

	// input fields
	logic [rmst_pkg::IDX_W-1:0] position, range_low, range_high;
	logic [VW-1:0]              new_value;
	logic                       func;

	assign position   = s_axis_tdata[9:0];
	assign new_value  = s_axis_tdata[69:10];
	assign range_low  = s_axis_tdata[79:70];
	assign range_high = s_axis_tdata[89:80];
	assign func       = s_axis_tuser;

	// state
	rmst_pkg::state_t state_q, state_d;
	logic [AW-1:0] clr_q, clr_d;
	logic [AW-1:0] node_q, node_d;
	logic          first_q, first_d;
	logic [VW-1:0] cur_q, cur_d;
	logic [NW-1:0] l_q, l_d, r_q, r_d;
	logic          pend_q, pend_d;
	logic [VW-1:0] best_q, best_d;
	logic          out_valid_q, out_valid_d;
	logic [VW-1:0] out_data_q, out_data_d;

	// RAM port signals
	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [VW-1:0] wdata, rdata;

	rmst_ram #(
		.WIDTH(VW),
		.DEPTH(DEPTH)
	) u_nodes (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// decoded index arithmetic on accept
	logic [31:0]   pos_ext, lo_ext, hi_ext, hi_sat;
	logic [VW-1:0] upd_min, fold;
	logic [AW-1:0] parent;

	assign pos_ext = 32'(position);
	assign lo_ext  = 32'(range_low);
	assign hi_ext  = 32'(range_high);
	assign hi_sat  = (hi_ext >= 32'(LEAVES)) ? 32'(LEAVES - 1) : hi_ext;

	assign upd_min = (rdata < cur_q) ? rdata : cur_q;
	assign fold    = (pend_q && (rdata < best_q)) ? rdata : best_q;
	assign parent  = node_q >> 1;

	assign s_axis_tready = (state_q == rmst_pkg::ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_data_q};

	// next state and RAM control
	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		node_d      = node_q;
		first_d     = first_q;
		cur_d       = cur_q;
		l_d         = l_q;
		r_d         = r_q;
		pend_d      = pend_q;
		best_d      = best_q;
		out_data_d  = out_data_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		we          = 1'b0;
		waddr       = clr_q;
		wdata       = rmst_pkg::INF_VAL;
		re          = 1'b0;
		raddr       = node_q;

		case (state_q)
			// sweep every node to infinity after reset
			rmst_pkg::ST_CLEAR: begin
				we    = 1'b1;
				clr_d = clr_q + 1'b1;
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = rmst_pkg::ST_IDLE;
				end
			end

			rmst_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					if (func == rmst_pkg::FUNC_UPDATE) begin
						// out-of-range positions are dropped
						if (pos_ext < 32'(LEAVES)) begin
							node_d  = AW'(pos_ext + 32'(LEAVES));
							cur_d   = new_value;
							first_d = 1'b1;
							state_d = rmst_pkg::ST_U_READ;
						end
					end else begin
						best_d = rmst_pkg::INF_VAL;
						pend_d = 1'b0;
						l_d    = NW'(lo_ext + 32'(LEAVES));
						r_d    = NW'(hi_sat + 32'(LEAVES) + 32'd1);
						// empty or inverted range goes straight to the result
						if (lo_ext > hi_sat) begin
							state_d = rmst_pkg::ST_Q_DONE;
						end else begin
							state_d = rmst_pkg::ST_Q_LEFT;
						end
					end
				end
			end

			// read the leaf first, then the sibling at each level
			rmst_pkg::ST_U_READ: begin
				re      = 1'b1;
				raddr   = first_q ? node_q : (node_q ^ AW'(1));
				state_d = rmst_pkg::ST_U_WRITE;
			end

			rmst_pkg::ST_U_WRITE: begin
				we      = 1'b1;
				waddr   = first_q ? node_q : parent;
				wdata   = upd_min;
				cur_d   = upd_min;
				node_d  = first_q ? node_q : parent;
				first_d = 1'b0;
				if (!first_q && (parent == AW'(1))) begin
					state_d = rmst_pkg::ST_IDLE;
				end else begin
					state_d = rmst_pkg::ST_U_READ;
				end
			end

			// left boundary step; folds a read issued by the right step
			rmst_pkg::ST_Q_LEFT: begin
				best_d = fold;
				pend_d = 1'b0;
				if (l_q >= r_q) begin
					state_d = rmst_pkg::ST_Q_DONE;
				end else begin
					if (l_q[0]) begin
						re     = 1'b1;
						raddr  = l_q[AW-1:0];
						pend_d = 1'b1;
						l_d    = l_q + 1'b1;
					end
					state_d = rmst_pkg::ST_Q_RIGHT;
				end
			end

			// right boundary step, then move both bounds up one level
			rmst_pkg::ST_Q_RIGHT: begin
				best_d = fold;
				pend_d = 1'b0;
				if (r_q[0]) begin
					re     = 1'b1;
					raddr  = AW'(r_q - 1'b1);
					pend_d = 1'b1;
				end
				l_d     = l_q >> 1;
				r_d     = r_q >> 1;
				state_d = rmst_pkg::ST_Q_LEFT;
			end

			// hand the result to the output register once it is free
			rmst_pkg::ST_Q_DONE: begin
				if (!out_valid_q || m_axis_tready) begin
					out_valid_d = 1'b1;
					out_data_d  = best_q;
					state_d     = rmst_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = rmst_pkg::ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rmst_pkg::ST_CLEAR;
			clr_q       <= '0;
			first_q     <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			clr_q       <= clr_d;
			first_q     <= first_d;
			pend_q      <= pend_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		node_q     <= node_d;
		cur_q      <= cur_d;
		l_q        <= l_d;
		r_q        <= r_d;
		best_q     <= best_d;
		out_data_q <= out_data_d;
	end

endmodule
`default_nettype wire

[dv/tb_range_min_segment_tree.sv]
// Testbench for the range-minimum segment tree: directed and random updates and queries.
`timescale 1ns / 100ps
module tb_range_min_segment_tree;

	localparam int LEAVES      = 1024;
	localparam int NUM_RANDOM  = 850;
	localparam int SETTLE      = 60;
	localparam int CYCLE_LIMIT = 400000;

	// one input item as the sender sees it
	typedef struct {
		logic                       func;
		logic [rmst_pkg::IDX_W-1:0] pos;
		logic [rmst_pkg::VAL_W-1:0] val;
		logic [rmst_pkg::IDX_W-1:0] lo;
		logic [rmst_pkg::IDX_W-1:0] hi;
	} tree_op_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;   // position[9:0], new_value[69:10], range_low[79:70],
	                             // range_high[89:80], zero[95:90]
	logic        s_axis_tuser;   // func[0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;   // minimum[59:0], zero[63:60]

	range_min_segment_tree #(.LEAVES(LEAVES)) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// predicted tree: node 1 is the root, leaf p sits at node LEAVES+p
	logic [rmst_pkg::VAL_W-1:0] seg_min [0:2*LEAVES-1];
	logic [rmst_pkg::VAL_W-1:0] expected_minima [$];
	tree_op_t                   pending_ops [$];

	tree_op_t                   drv_op;
	logic [rmst_pkg::VAL_W-1:0] want_min;
	logic                       in_taken;
	logic                       calm;
	int                         gap_left;
	int                         burst_left;
	int                         rx_hold;
	int                         cycle_count;
	int                         err_count;

	always #10 clk = ~clk;

	// lower one leaf and refresh the minima up to the root
	function automatic void apply_min_update(logic [rmst_pkg::IDX_W-1:0] p,
			logic [rmst_pkg::VAL_W-1:0] v);
		int node;
		node = int'(p) + LEAVES;
		if (v < seg_min[node])
			seg_min[node] = v;
		while (node > 1) begin
			node = node >> 1;
			seg_min[node] = (seg_min[2*node] < seg_min[2*node+1]) ?
				seg_min[2*node] : seg_min[2*node+1];
		end
	endfunction

	// bottom-up walk over the inclusive range; empty or inverted gives infinity
	function automatic logic [rmst_pkg::VAL_W-1:0] range_minimum(
			logic [rmst_pkg::IDX_W-1:0] lo, logic [rmst_pkg::IDX_W-1:0] hi);
		logic [rmst_pkg::VAL_W-1:0] best;
		int l;
		int r;
		int top;
		best = rmst_pkg::INF_VAL;
		top = (int'(hi) >= LEAVES) ? LEAVES - 1 : int'(hi);
		if (int'(lo) <= top) begin
			l = int'(lo) + LEAVES;
			r = top + LEAVES + 1;
			while (l < r) begin
				if (l[0]) begin
					if (seg_min[l] < best) best = seg_min[l];
					l++;
				end
				if (r[0]) begin
					r--;
					if (seg_min[r] < best) best = seg_min[r];
				end
				l = l >> 1;
				r = r >> 1;
			end
		end
		return best;
	endfunction

	function automatic logic [rmst_pkg::VAL_W-1:0] rand_val60();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[rmst_pkg::VAL_W-1:0];
	endfunction

	// value spread: small, full width, shifted full width, just under and just over infinity
	function automatic logic [rmst_pkg::VAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return rmst_pkg::VAL_W'($urandom_range(0, 1000000));
			4, 5, 6:    return rand_val60();
			7:          return rmst_pkg::INF_VAL - rmst_pkg::VAL_W'($urandom_range(0, 50));
			8:          return rmst_pkg::INF_VAL + rmst_pkg::VAL_W'($urandom_range(0, 50));
			default:    return rand_val60() >> $urandom_range(1, 40);
		endcase
	endfunction

	// unused fields of each item carry random bits
	task automatic add_update(int p, logic [rmst_pkg::VAL_W-1:0] v);
		tree_op_t op;
		op.func = rmst_pkg::FUNC_UPDATE;
		op.pos  = rmst_pkg::IDX_W'(p);
		op.val  = v;
		op.lo   = rmst_pkg::IDX_W'($urandom);
		op.hi   = rmst_pkg::IDX_W'($urandom);
		pending_ops.push_back(op);
	endtask

	task automatic add_query(int lo, int hi);
		tree_op_t op;
		op.func = rmst_pkg::FUNC_QUERY;
		op.pos  = rmst_pkg::IDX_W'($urandom);
		op.val  = rand_val60();
		op.lo   = rmst_pkg::IDX_W'(lo);
		op.hi   = rmst_pkg::IDX_W'(hi);
		pending_ops.push_back(op);
	endtask

	// driver and receiver, both changing at the falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (gap_left > 0) begin
					s_axis_tvalid <= 1'b0;
					gap_left--;
				end else if (pending_ops.size() > 0) begin
					drv_op = pending_ops.pop_front();
					s_axis_tdata  <= {6'd0, drv_op.hi, drv_op.lo, drv_op.val, drv_op.pos};
					s_axis_tuser  <= drv_op.func;
					s_axis_tvalid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = calm ? 200 : $urandom_range(0, 12);
						gap_left   = calm ? 0 : $urandom_range(1, 8);
					end
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (rx_hold > 0) begin
				m_axis_tready <= 1'b0;
				rx_hold--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					rx_hold = $urandom_range(1, 10);
			end
		end
	end

	// accept tracking, prediction, result check and timeout at the rising edge
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 512 == 0)
			calm = ($urandom_range(0, 3) == 0);
		in_taken = (s_axis_tvalid === 1'b1) && (s_axis_tready === 1'b1);
		if (in_taken) begin
			if (s_axis_tuser == rmst_pkg::FUNC_UPDATE)
				apply_min_update(s_axis_tdata[9:0], s_axis_tdata[69:10]);
			else
				expected_minima.push_back(range_minimum(s_axis_tdata[79:70],
					s_axis_tdata[89:80]));
		end
		if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
			if (expected_minima.size() == 0) begin
				err_count++;
				if (err_count <= 10)
					$display("unexpected result item: minimum %0d", m_axis_tdata[59:0]);
			end else begin
				want_min = expected_minima.pop_front();
				if (m_axis_tdata[59:0] !== want_min) begin
					err_count++;
					if (err_count <= 10)
						$display("minimum mismatch: expected %0d, got %0d",
							want_min, m_axis_tdata[59:0]);
				end
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		int kind;
		int lo;
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = rmst_pkg::FUNC_UPDATE;
		m_axis_tready = 1'b0;
		in_taken      = 1'b0;
		calm          = 1'b0;
		gap_left      = 0;
		burst_left    = 0;
		rx_hold       = 0;
		cycle_count   = 0;
		err_count     = 0;
		for (int i = 0; i < 2*LEAVES; i++)
			seg_min[i] = rmst_pkg::INF_VAL;

		// directed: untouched tree, inverted ranges, extremes, values above infinity
		add_query(0, LEAVES-1);
		add_query(5, 3);
		add_update(0, '0);
		add_update(LEAVES-1, {rmst_pkg::VAL_W{1'b1}});
		add_update(LEAVES-1, rmst_pkg::INF_VAL + 1);
		add_query(LEAVES-1, LEAVES-1);
		add_query(0, 0);
		add_update(512, 12345);
		add_query(1, LEAVES-1);
		add_update(LEAVES-1, 7);
		add_query(1000, LEAVES-1);
		add_query(LEAVES-1, 0);
		add_update(300, rmst_pkg::INF_VAL - 1);
		add_query(200, 400);
		add_query(0, LEAVES-1);
		add_update(512, 99999);
		add_query(512, 512);
		add_update(1022, 60'h555_5555_5555_5555);
		add_query(1022, 1022);
		add_update(1021, rmst_pkg::INF_VAL);
		add_query(1021, 1021);
		add_query(513, 1021);

		// random mix of updates and queries; half of the queries use narrow ranges
		for (int n = 0; n < NUM_RANDOM; n++) begin
			if ($urandom_range(0, 99) < 45) begin
				add_update($urandom_range(0, LEAVES-1), pick_value());
			end else begin
				kind = $urandom_range(0, 9);
				lo   = $urandom_range(0, LEAVES-1);
				case (kind)
					0, 1:    add_query($urandom_range(0, LEAVES-1),
						$urandom_range(0, LEAVES-1));
					2:       add_query(lo, lo);
					3:       add_query(0, $urandom_range(0, LEAVES-1));
					4:       add_query(lo, LEAVES-1);
					5:       add_query(lo, (lo > 0) ? $urandom_range(0, lo-1) : 0);
					default: add_query(lo, (lo + $urandom_range(0, 40) > LEAVES-1) ?
						LEAVES-1 : lo + $urandom_range(0, 40));
				endcase
			end
		end

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// wait for every item to be taken, then for every result
		while (pending_ops.size() != 0 || s_axis_tvalid)
			@(negedge clk);
		while (expected_minima.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[files.f]
rtl/rmst_pkg.sv
rtl/rmst_ram.sv
rtl/range_min_segment_tree.sv
dv/tb_range_min_segment_tree.sv
